// File: design/aes128_pkg.sv
`default_nettype none
package aes128_pkg;
	localparam int NUM_RKEYS = 11;
	localparam int LAST_KEY = 10;
	localparam int KEY_ENTRIES = 2 * NUM_RKEYS;
	localparam int KEY_AW = $clog2(NUM_RKEYS);
	localparam int RND_W = 4;

	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_ENC = 2'd1;
	localparam logic [1:0] CMD_DEC = 2'd2;

	typedef struct packed {
		logic [1:0] command;
		logic [3:0] key_round;
		logic key_half;
		logic [63:0] data_high;
		logic [63:0] data_low;
	} aes128_in_t;

	typedef struct packed {
		logic [63:0] result_high;
		logic [63:0] result_low;
	} aes128_out_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_block;  // take the input block into the state register
		logic key_write;   // write one key half
		logic key_read;    // read both halves of the key for key_rnd
		logic [RND_W-1:0] key_rnd;
		logic do_round;    // apply one round using the key read last cycle
		logic last_mix;    // this round omits MixColumns
		logic final_xor;   // apply the last key only
		logic inverse;
	} aes128_cmd_t;

	localparam logic [7:0] SBOX [256] = '{
	8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
	8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
	8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
	8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
	8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
	8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
	8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
	8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
	8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
	8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
	8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
	8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
	8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
	8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
	8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
	8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

	localparam logic [7:0] INV_SBOX [256] = '{
	8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
	8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
	8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
	8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
	8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
	8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
	8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
	8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
	8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
	8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
	8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
	8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
	8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
	8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
	8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
	8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

	function automatic logic [7:0] xtime(input logic [7:0] b);
		xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction
endpackage
`default_nettype wire

// File: design/aes128_if.sv
`default_nettype none
interface aes128_in_if;
	import aes128_pkg::*;
	logic valid;
	logic ready;
	aes128_in_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface aes128_out_if;
	import aes128_pkg::*;
	logic valid;
	logic ready;
	aes128_out_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: design/aes128_ram.sv
`default_nettype none
module aes128_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: design/aes128_datapath.sv
`default_nettype none
module aes128_datapath (
	input wire logic clk,
	input wire aes128_pkg::aes128_cmd_t cmd,
	input wire aes128_pkg::aes128_in_t din,
	output aes128_pkg::aes128_out_t dout
);
	import aes128_pkg::*;

	logic [127:0] state_q;
	logic [63:0] key_hi, key_lo;
	logic [127:0] keyed, sub, mixed;
	logic [7:0] kb [16];
	logic [7:0] tb [16];
	logic [7:0] mb [16];

	// Two banks, one per key half, so the whole round key arrives in one read.
	aes128_ram #(.WIDTH(64), .DEPTH(NUM_RKEYS)) u_hi (
		.clk(clk), .we(cmd.key_write && !din.key_half),
		.waddr(din.key_round[KEY_AW-1:0]), .wdata(din.data_high),
		.raddr(cmd.key_rnd[KEY_AW-1:0]), .rdata(key_hi));
	aes128_ram #(.WIDTH(64), .DEPTH(NUM_RKEYS)) u_lo (
		.clk(clk), .we(cmd.key_write && din.key_half),
		.waddr(din.key_round[KEY_AW-1:0]), .wdata(din.data_high),
		.raddr(cmd.key_rnd[KEY_AW-1:0]), .rdata(key_lo));

	always_comb begin
		keyed = state_q ^ {key_hi, key_lo};
		for (int i = 0; i < 16; i++) begin
			kb[i] = keyed[127 - 8*i -: 8];
		end
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				if (cmd.inverse) begin
					tb[r + 4*c] = INV_SBOX[kb[r + 4*((c + 4 - r) % 4)]];
				end else begin
					tb[r + 4*c] = SBOX[kb[r + 4*((c + r) % 4)]];
				end
			end
		end
		for (int c = 0; c < 4; c++) begin
			logic [7:0] a0, a1, a2, a3, x0, x1, x2, x3, u, v;
			a0 = tb[4*c]; a1 = tb[4*c+1]; a2 = tb[4*c+2]; a3 = tb[4*c+3];
			if (cmd.inverse) begin
				// The inverse mix is a forward mix after a fixed pre-step on the column.
				u = xtime(xtime(a0 ^ a2));
				v = xtime(xtime(a1 ^ a3));
				a0 = a0 ^ u;
				a1 = a1 ^ v;
				a2 = a2 ^ u;
				a3 = a3 ^ v;
			end else begin
				u = 8'h00;
				v = 8'h00;
			end
			x0 = xtime(a0); x1 = xtime(a1); x2 = xtime(a2); x3 = xtime(a3);
			mb[4*c]   = x0 ^ x1 ^ a1 ^ a2 ^ a3;
			mb[4*c+1] = a0 ^ x1 ^ x2 ^ a2 ^ a3;
			mb[4*c+2] = a0 ^ a1 ^ x2 ^ x3 ^ a3;
			mb[4*c+3] = x0 ^ a0 ^ a1 ^ a2 ^ x3;
		end
		for (int i = 0; i < 16; i++) begin
			sub[127 - 8*i -: 8] = tb[i];
			mixed[127 - 8*i -: 8] = mb[i];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_block) begin
			state_q <= {din.data_high, din.data_low};
		end else if (cmd.final_xor) begin
			state_q <= keyed;
		end else if (cmd.do_round) begin
			state_q <= cmd.last_mix ? sub : mixed;
		end
	end

	assign dout.result_high = state_q[127:64];
	assign dout.result_low = state_q[63:0];
endmodule
`default_nettype wire

// File: design/aes128_ctrl.sv
`default_nettype none
module aes128_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire aes128_pkg::aes128_in_t din,
	output logic out_valid,
	input wire logic out_ready,
	output aes128_pkg::aes128_cmd_t cmd
);
	import aes128_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0] state_q;
	logic [RND_W-1:0] rnd_q;
	logic inv_q;
	logic acc;
	logic is_cipher;

	assign in_ready = (state_q == ST_IDLE) || (state_q == ST_DONE && out_ready);
	assign out_valid = (state_q == ST_DONE);
	assign acc = in_valid && in_ready;
	assign is_cipher = (din.command == CMD_ENC) || (din.command == CMD_DEC);

	always_comb begin
		cmd = '0;
		cmd.inverse = inv_q;
		cmd.key_write = acc && din.command == CMD_LOAD
			&& din.key_round < RND_W'(NUM_RKEYS);
		cmd.load_block = acc && is_cipher;
		cmd.key_read = 1'b1;
		cmd.key_rnd = cmd.load_block ? '0 : rnd_q + 1'b1;
		if (state_q == ST_RUN) begin
			cmd.do_round = (rnd_q != RND_W'(LAST_KEY));
			cmd.last_mix = (rnd_q == RND_W'(LAST_KEY - 1));
			cmd.final_xor = (rnd_q == RND_W'(LAST_KEY));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q <= '0;
			inv_q <= 1'b0;
		end else begin
			unique case (state_q) inside
				ST_IDLE, ST_DONE: begin
					if (state_q == ST_DONE && out_ready) begin
						state_q <= ST_IDLE;
					end
					if (acc && is_cipher) begin
						state_q <= ST_RUN;
						rnd_q <= '0;
						inv_q <= (din.command == CMD_DEC);
					end
				end
				ST_RUN: begin
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == RND_W'(LAST_KEY)) begin
						state_q <= ST_DONE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: design/aes128_block_cipher_core.sv
`default_nettype none
// AES-128 block core. An input item carries one of three commands: load one
// 64-bit half of a round key (no result), encrypt a block, or decrypt a block
// (one result item each). The round keys live in two small RAM banks, one per
// key half, read once per cycle; an iterative round unit applies one round per
// cycle, so a cipher item runs ten rounds and the final key addition, each using
// one round key read the cycle before, and a key load is written when accepted.
// The result is held until taken, and the next item is accepted in the same
// cycle the result leaves. Decryption uses the keys in stored order, so an
// equivalent-inverse schedule must be loaded for it.
module aes128_block_cipher_core (
	input wire logic clk,
	input wire logic arst_n,
	aes128_in_if.sink in_ch,
	aes128_out_if.source out_ch
);
	import aes128_pkg::*;

	aes128_cmd_t cmd;

	// The controller sequences rounds; the datapath holds state and keys.
	aes128_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .din(in_ch.payload),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .cmd(cmd));

	aes128_datapath u_dp (
		.clk(clk), .cmd(cmd), .din(in_ch.payload), .dout(out_ch.payload));
endmodule
`default_nettype wire

// File: test/aes128_cipher_checker.sv
`default_nettype none
// Watches both channels of the cipher core. It keeps its own copy of the
// round key store, works out every cipher result on acceptance and compares
// each returned item with the oldest one still outstanding.
module aes128_cipher_checker (
	input wire logic clk,
	input wire logic arst_n,
	aes128_in_if in_ch,
	aes128_out_if out_ch,
	output int errors,
	output int pending,
	output int enc_seen,
	output int dec_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import aes128_pkg::*;

	logic [63:0] key_copy [KEY_ENTRIES];
	logic [7:0] inv_box [256];
	aes128_out_t expected_blocks [$];

	initial begin
		for (int i = 0; i < 256; i++) begin
			inv_box[SBOX[i]] = 8'(i);
		end
	end

	function automatic logic [7:0] dbl(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [3:0] m);
		logic [7:0] acc;
		acc = 8'h00;
		for (int i = 0; i < 4; i++) begin
			if (m[i]) begin
				acc ^= a;
			end
			a = dbl(a);
		end
		return acc;
	endfunction

	function automatic aes128_out_t run_cipher(input logic [63:0] hi, input logic [63:0] lo,
			input logic inv);
		logic [7:0] st [16];
		logic [7:0] tmp [16];
		logic [7:0] kb [16];
		logic [127:0] blk;
		logic [127:0] kw;
		logic [3:0] coef [4];
		int src;
		blk = {hi, lo};
		for (int i = 0; i < 16; i++) begin
			st[i] = blk[127 - 8 * i -: 8];
		end
		if (inv) begin
			coef = '{4'd14, 4'd11, 4'd13, 4'd9};
		end else begin
			coef = '{4'd2, 4'd3, 4'd1, 4'd1};
		end
		for (int rnd = 0; rnd <= LAST_KEY; rnd++) begin
			kw = {key_copy[2 * rnd], key_copy[2 * rnd + 1]};
			for (int i = 0; i < 16; i++) begin
				st[i] ^= kw[127 - 8 * i -: 8];
			end
			if (rnd == LAST_KEY) begin
				break;
			end
			// Row shift and byte substitution in one pass.
			for (int c = 0; c < 4; c++) begin
				for (int r = 0; r < 4; r++) begin
					src = inv ? ((c + 4 - r) % 4) : ((c + r) % 4);
					tmp[r + 4 * c] = inv ? inv_box[st[r + 4 * src]] : SBOX[st[r + 4 * src]];
				end
			end
			st = tmp;
			if (rnd + 1 < LAST_KEY) begin
				for (int c = 0; c < 4; c++) begin
					for (int r = 0; r < 4; r++) begin
						kb[r] = 8'h00;
						for (int j = 0; j < 4; j++) begin
							kb[r] ^= gf_mul(st[4 * c + j], coef[(j + 4 - r) % 4]);
						end
					end
					for (int r = 0; r < 4; r++) begin
						tmp[4 * c + r] = kb[r];
					end
				end
				st = tmp;
			end
		end
		for (int i = 0; i < 16; i++) begin
			blk[127 - 8 * i -: 8] = st[i];
		end
		return '{result_high: blk[127:64], result_low: blk[63:0]};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		aes128_out_t want;
		aes128_in_t it;
		if (!arst_n) begin
			expected_blocks.delete();
			errors <= 0;
			pending <= 0;
			enc_seen <= 0;
			dec_seen <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_blocks.size() == 0) begin
					if (errors < 10) begin
						$display("%0t: unexpected result %h_%h", $realtime,
							out_ch.payload.result_high, out_ch.payload.result_low);
					end
					errors <= errors + 1;
				end else begin
					want = expected_blocks.pop_front();
					if (out_ch.payload.result_high !== want.result_high ||
							out_ch.payload.result_low !== want.result_low) begin
						if (errors < 10) begin
							$display("%0t: result mismatch high exp %h got %h, low exp %h got %h",
								$realtime, want.result_high, out_ch.payload.result_high,
								want.result_low, out_ch.payload.result_low);
						end
						errors <= errors + 1;
					end
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				it = in_ch.payload;
				if (it.command == CMD_LOAD) begin
					if (it.key_round < NUM_RKEYS) begin
						key_copy[2 * it.key_round + it.key_half] = it.data_high;
					end
				end else if (it.command == CMD_ENC || it.command == CMD_DEC) begin
					expected_blocks.push_back(run_cipher(it.data_high, it.data_low,
						it.command == CMD_DEC));
					if (it.command == CMD_ENC) begin
						enc_seen <= enc_seen + 1;
					end else begin
						dec_seen <= dec_seen + 1;
					end
				end
			end
			pending <= expected_blocks.size();
		end
	end
endmodule
`default_nettype wire

// File: test/aes128_block_cipher_core_test.sv
`default_nettype none
// Top of the cipher core bench. It makes the clock and the single reset,
// drives command items into the core with random gaps, stalls the result
// channel at random, and gives the verdict from the checker's error and pending counts.
module aes128_block_cipher_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import aes128_pkg::*;

	logic clk;
	logic arst_n;
	// While set, neither side of the core idles.
	logic steady;
	int errors;
	int pending;
	int enc_seen;
	int dec_seen;
	int loads_sent;

	aes128_in_if in_ch ();
	aes128_out_if out_ch ();

	aes128_block_cipher_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	aes128_cipher_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.errors(errors),
		.pending(pending),
		.enc_seen(enc_seen),
		.dec_seen(dec_seen)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// The result side is stalled in about one cycle of five, except in the
	// steady stretch.
	always @(posedge clk) begin
		out_ch.ready <= steady ? 1'b1 : ($urandom_range(99) >= 19);
	end

	// Offers one item and holds it until the core takes it. The valid line is
	// only lowered when a gap follows, so back-to-back items keep it high
	// without a second assignment in the same step.
	task automatic offer(input logic [1:0] cmd, input logic [3:0] rnd, input logic half,
			input logic [63:0] hi, input logic [63:0] lo);
		in_ch.valid <= 1'b1;
		in_ch.payload <= '{command: cmd, key_round: rnd, key_half: half,
			data_high: hi, data_low: lo};
		do begin
			@(posedge clk);
		end while (!in_ch.ready);
		if (cmd == CMD_LOAD) begin
			loads_sent++;
		end
		if (!steady && $urandom_range(99) < 19) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	initial begin
		logic [1:0] cmd;
		int pick;
		loads_sent = 0;
		steady = 1'b0;
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.payload <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every key half is written before any cipher item, since a key that
		// was never written must not be read.
		for (int k = 0; k < NUM_RKEYS; k++) begin
			offer(CMD_LOAD, 4'(k), 1'b0, rand64(), rand64());
			offer(CMD_LOAD, 4'(k), 1'b1, rand64(), rand64());
		end

		// Directed part: extreme blocks in both directions, loads that fall
		// beyond the store, the unused command, and a key update between
		// two ciphers.
		offer(CMD_ENC, 4'd0, 1'b0, '0, '0);
		offer(CMD_ENC, 4'd15, 1'b1, '1, '1);
		offer(CMD_DEC, 4'd0, 1'b0, '0, '0);
		offer(CMD_DEC, 4'd15, 1'b1, '1, '1);
		offer(CMD_LOAD, 4'd11, 1'b0, '1, '1);
		offer(CMD_LOAD, 4'd15, 1'b1, '0, '1);
		offer(2'd3, 4'd5, 1'b1, '1, '1);
		offer(CMD_ENC, 4'd0, 1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
		offer(CMD_LOAD, 4'd10, 1'b1, '0, '1);
		offer(CMD_LOAD, 4'd0, 1'b0, '1, '0);
		offer(CMD_DEC, 4'd0, 1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
		offer(CMD_ENC, 4'd0, 1'b0, 64'h8000000000000000, 64'h0000000000000001);

		// Random part: mostly cipher items over a key store that keeps
		// changing, with loads to any round number and the unused command.
		for (int n = 0; n < 1750; n++) begin
			steady = (n >= 700 && n < 950);
			pick = $urandom_range(99);
			if (pick < 40) begin
				cmd = CMD_ENC;
			end else if (pick < 80) begin
				cmd = CMD_DEC;
			end else if (pick < 96) begin
				cmd = CMD_LOAD;
			end else begin
				cmd = 2'd3;
			end
			offer(cmd, 4'($urandom_range(15)), 1'($urandom_range(1)), rand64(), rand64());
		end
		steady = 1'b0;
		in_ch.valid <= 1'b0;

		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (30) @(posedge clk);
		$display("Ran %0d encrypt and %0d decrypt blocks and %0d key loads under random stalls.",
			enc_seen, dec_seen, loads_sent);
		if (errors == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatching or missing results.", errors + pending);
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("Timed out with %0d results outstanding.", pending);
		$display("FAIL");
		$finish;
	end
endmodule
`default_nettype wire

// File: sim.f
design/aes128_pkg.sv
design/aes128_if.sv
design/aes128_ram.sv
design/aes128_datapath.sv
design/aes128_ctrl.sv
design/aes128_block_cipher_core.sv
test/aes128_cipher_checker.sv
test/aes128_block_cipher_core_test.sv
